[hw/rtl/char_lcd_nibble_writer_defines.svh]
// Assertion macros shared by the character LCD nibble writer.
// Stand-alone header; no dependencies.
`ifndef CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH

`define CLNW_ASSERT_NEXT(label, clk, rst_n, cond, expect_next, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
        else $error(msg);

`define CLNW_ASSERT_NOW(label, clk, rst_n, cond, expect_now, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
        else $error(msg);

`endif

[hw/rtl/clnw_pkg.sv]
// Types, constants and the power-up table of the character LCD nibble writer.
// No dependencies.
`timescale 1ns / 1ps

package clnw_pkg;

    localparam int ROW_COUNT   = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [5:0] LINE_LENGTH_RESET = 6'd20;
    localparam logic [7:0] ROW_BASE_0_RESET  = 8'h80;
    localparam logic [7:0] ROW_BASE_1_RESET  = 8'hC0;
    localparam logic [7:0] ROW_BASE_2_RESET  = 8'h94;
    localparam logic [7:0] ROW_BASE_3_RESET  = 8'hD4;

    localparam logic [7:0] CMD_WAKE         = 8'h33;
    localparam logic [7:0] CMD_FOUR_BIT     = 8'h22;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_SHIFT        = 8'h10;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;

    // Number of nibbles in the power-up prefix ahead of the trailing clear.
    localparam logic [4:0] INIT_STEPS = 5'd14;

    typedef enum logic [1:0] {
        FUNC_SHOW_CHAR  = 2'd0,
        FUNC_SET_CURSOR = 2'd1,
        FUNC_CLEAR      = 2'd2,
        FUNC_INIT       = 2'd3
    } clnw_func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_LENGTH = 3'd0,
        REG_ROW_BASE_0  = 3'd1,
        REG_ROW_BASE_1  = 3'd2,
        REG_ROW_BASE_2  = 3'd3,
        REG_ROW_BASE_3  = 3'd4
    } clnw_reg_t;

    // One queued job: optional power-up prefix, byte a, optional command byte b.
    typedef struct packed {
        logic       prefix;
        logic       a_rs;
        logic [7:0] a;
        logic       has_b;
        logic [7:0] b;
    } clnw_job_t;

    typedef struct packed {
        logic [5:0] col;
        logic [1:0] row;
    } clnw_cursor_t;

    typedef struct packed {
        logic       long_wait;
        logic [3:0] val;
    } clnw_nib_t;

    function automatic clnw_nib_t init_nibble(input logic [3:0] idx);
        clnw_nib_t r;
        r.long_wait = 1'b0;
        unique case (idx)
            4'd0, 4'd1, 4'd2: r.val = CMD_WAKE[3:0];
            4'd3:  r.val = CMD_FOUR_BIT[3:0];
            4'd4:  r.val = CMD_FUNCTION_SET[7:4];
            4'd5:  r.val = CMD_FUNCTION_SET[3:0];
            4'd6:  r.val = CMD_CLEAR[7:4];
            4'd7:
            begin
                r.val       = CMD_CLEAR[3:0];
                r.long_wait = 1'b1;
            end
            4'd8:  r.val = CMD_SHIFT[7:4];
            4'd9:  r.val = CMD_SHIFT[3:0];
            4'd10: r.val = CMD_ENTRY_MODE[7:4];
            4'd11: r.val = CMD_ENTRY_MODE[3:0];
            4'd12: r.val = CMD_DISPLAY_ON[7:4];
            4'd13: r.val = CMD_DISPLAY_ON[3:0];
            default: r.val = 4'h0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/clnw_front.sv]
// Front end: configuration registers, cursor tracking and job classification.
// Depends on clnw_pkg.
`timescale 1ns / 1ps

module clnw_front
    import clnw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  logic [7:0]             char_code,
    input  logic [5:0]             target_column,
    input  logic [1:0]             target_row,
    input  logic                   queue_full,
    output logic                   push,
    output clnw_job_t              job,
    output clnw_cursor_t           cursor
);

    logic [5:0] line_length_reg;
    logic [7:0] row_base_0_reg;
    logic [7:0] row_base_1_reg;
    logic [7:0] row_base_2_reg;
    logic [7:0] row_base_3_reg;
    logic [5:0] col_reg;
    logic [5:0] col_next;
    logic [1:0] row_reg;
    logic [1:0] row_next;

    logic [6:0] col_inc;
    logic       wrap;
    logic [1:0] row_inc;
    logic [7:0] set_addr;
    logic [1:0] row_clamp;

    function automatic logic [7:0] row_base(input logic [1:0] sel, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2,
                                            input logic [7:0] b3);
        logic [7:0] r;
        unique case (sel)
            2'd0: r = b0;
            2'd1: r = b1;
            2'd2: r = b2;
            default: r = b3;
        endcase
        return r;
    endfunction

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;
    assign cursor   = '{col: col_reg, row: row_reg};

    always_comb
    begin
        col_inc   = {1'b0, col_reg} + 7'd1;
        wrap      = col_inc >= {1'b0, line_length_reg};
        row_inc   = (({1'b0, row_reg} + 3'd1) >= 3'(ROW_COUNT)) ? 2'd0 : row_reg + 2'd1;
        set_addr  = row_base(target_row, row_base_0_reg, row_base_1_reg, row_base_2_reg,
                             row_base_3_reg) + {2'b00, target_column};
        row_clamp = ({1'b0, target_row} >= 3'(ROW_COUNT)) ? 2'(ROW_COUNT - 1) : target_row;

        job.prefix = 1'b0;
        job.a_rs   = 1'b0;
        job.a      = CMD_CLEAR;
        job.has_b  = 1'b1;
        job.b      = row_base_0_reg;
        col_next   = '0;
        row_next   = '0;

        unique case (clnw_func_t'(func))
            FUNC_SHOW_CHAR:
            begin
                job.a_rs  = 1'b1;
                job.a     = char_code;
                job.has_b = wrap;
                job.b     = row_base(row_inc, row_base_0_reg, row_base_1_reg, row_base_2_reg,
                                     row_base_3_reg);
                col_next  = wrap ? 6'd0 : col_inc[5:0];
                row_next  = wrap ? row_inc : row_reg;
            end
            FUNC_SET_CURSOR:
            begin
                job.a     = set_addr;
                job.has_b = 1'b0;
                col_next  = target_column;
                row_next  = row_clamp;
            end
            FUNC_CLEAR:
            begin
                job.prefix = 1'b0;
            end
            FUNC_INIT:
            begin
                job.prefix = 1'b1;
            end
            default:
            begin
                job.prefix = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= LINE_LENGTH_RESET;
            row_base_0_reg  <= ROW_BASE_0_RESET;
            row_base_1_reg  <= ROW_BASE_1_RESET;
            row_base_2_reg  <= ROW_BASE_2_RESET;
            row_base_3_reg  <= ROW_BASE_3_RESET;
        end
        else if (cfg_write)
        begin
            unique case (clnw_reg_t'(cfg_index))
                REG_LINE_LENGTH: line_length_reg <= cfg_data[5:0];
                REG_ROW_BASE_0:  row_base_0_reg  <= cfg_data;
                REG_ROW_BASE_1:  row_base_1_reg  <= cfg_data;
                REG_ROW_BASE_2:  row_base_2_reg  <= cfg_data;
                REG_ROW_BASE_3:  row_base_3_reg  <= cfg_data;
                default:         line_length_reg <= line_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[hw/rtl/clnw_queue.sv]
// Short job queue between the front end and the nibble sequencer.
// Depends on clnw_pkg.
`timescale 1ns / 1ps

module clnw_queue
    import clnw_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  clnw_job_t push_job,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output clnw_job_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    clnw_job_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/clnw_back.sv]
// Back end: expands queued jobs into nibble transfers behind an output register.
// Depends on clnw_pkg.
`timescale 1ns / 1ps

module clnw_back
    import clnw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  clnw_job_t head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      reg_select,
    output logic [3:0] nibble,
    output logic      long_wait,
    output logic      last
);

    logic [4:0] step_reg;
    logic [4:0] step_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       rs_reg;
    logic [3:0] nibble_reg;
    logic       long_wait_reg;
    logic       last_reg;

    logic [4:0] pos;
    logic [4:0] byte_pos;
    logic [1:0] k;
    logic [7:0] cur_byte;
    logic       cur_rs;
    logic       cur_lw;
    logic       cur_last;
    logic [3:0] cur_nibble;
    logic       load;
    clnw_nib_t  table_nib;

    assign out_valid  = out_valid_reg;
    assign reg_select = rs_reg;
    assign nibble     = nibble_reg;
    assign long_wait  = long_wait_reg;
    assign last       = last_reg;

    always_comb
    begin
        pos       = head.prefix ? step_reg : step_reg + INIT_STEPS;
        byte_pos  = pos - INIT_STEPS;
        k         = byte_pos[1:0];
        table_nib = init_nibble(pos[3:0]);
        cur_byte  = k[1] ? head.b : head.a;
        cur_rs    = k[1] ? 1'b0 : head.a_rs;

        if (pos < INIT_STEPS)
        begin
            cur_rs     = 1'b0;
            cur_nibble = table_nib.val;
            cur_lw     = table_nib.long_wait;
            cur_last   = 1'b0;
        end
        else
        begin
            cur_nibble = k[0] ? cur_byte[3:0] : cur_byte[7:4];
            cur_lw     = k[0] && !cur_rs && (cur_byte == CMD_CLEAR);
            cur_last   = (k == 2'd3) || (k == 2'd1 && !head.has_b);
        end

        load           = head_valid && (!out_valid_reg || out_ready);
        pop            = load && cur_last;
        step_next      = load ? (cur_last ? 5'd0 : step_reg + 5'd1) : step_reg;
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rs_reg        <= cur_rs;
            nibble_reg    <= cur_nibble;
            long_wait_reg <= cur_lw;
            last_reg      <= cur_last;
        end
    end

endmodule

[hw/rtl/char_lcd_nibble_writer.sv]
// With the queue empty, a word is registered in the job queue and its first nibble then in the output register.
// Throughput: the sequencer issues one nibble per cycle while a job is queued and out_ready does not
// stall the output register; a character is 2 or 4 nibbles, set-cursor 2, clear 4 and initialise 18.
// The job queue lets the front end keep accepting words while nibbles drain.
// Reset clears the cursor, queue and output valid and loads the default row bases.
// Depends on clnw_pkg, clnw_front, clnw_queue, clnw_back and the defines header.
`timescale 1ns / 1ps
`include "char_lcd_nibble_writer_defines.svh"

module char_lcd_nibble_writer
    import clnw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  logic [7:0]             char_code,
    input  logic [5:0]             target_column,
    input  logic [1:0]             target_row,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   reg_select,
    output logic [3:0]             nibble,
    output logic                   long_wait,
    output logic                   last
);

    logic         push;
    logic         pop;
    logic         full;
    logic         head_valid;
    clnw_job_t    push_job;
    clnw_job_t    head;
    clnw_cursor_t cursor;

    clnw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .char_code     (char_code),
        .target_column (target_column),
        .target_row    (target_row),
        .queue_full    (full),
        .push          (push),
        .job           (push_job),
        .cursor        (cursor)
    );

    clnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    clnw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_select (reg_select),
        .nibble     (nibble),
        .long_wait  (long_wait),
        .last       (last)
    );

    // A clear or initialise word always leaves the cursor at the home position.
    `CLNW_ASSERT_NEXT(a_clear_homes, clk, rst_n,
                      push && (func == FUNC_CLEAR || func == FUNC_INIT),
                      cursor.col == 6'd0 && cursor.row == 2'd0,
                      "cursor not homed after clear")
    `CLNW_ASSERT_NEXT(a_set_column, clk, rst_n,
                      push && func == FUNC_SET_CURSOR,
                      cursor.col == $past(target_column),
                      "cursor column not taken from set-cursor word")
    `CLNW_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, pop, out_valid && last,
                      "job retired without a final nibble")
    `CLNW_ASSERT_NOW(a_pop_needs_head, clk, rst_n, pop, head_valid,
                     "job retired from an empty queue")

endmodule
